// ===== design/command_triggered_sample_reporter_defines.svh =====
// assertion macros for the command triggered sample reporter checker
// expects signals clk and rst_n in the scope of use
`ifndef COMMAND_TRIGGERED_SAMPLE_REPORTER_DEFINES_SVH
`define COMMAND_TRIGGERED_SAMPLE_REPORTER_DEFINES_SVH

// same-cycle implication
`define CTSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ctsr_pkg.sv =====
// shared types and character constants for the sample reporter
// no dependencies
package ctsr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DIGITS      = 4;

    localparam logic [15:0] PERIOD_RESET = 16'd1000;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef struct packed {
        logic                   echo_en;
        logic [7:0]             echo_byte;
        logic                   frame_en;
        logic [SAMPLE_BITS-1:0] sample;
    } job_t;

endpackage

// ===== design/ctsr_front.sv =====
// front end: command parser, repeat timer and link machine, one item per cycle while q_full is low
// depends on ctsr_pkg
module ctsr_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [15:0]                      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [7:0]                       rx_byte,
    input  logic [ctsr_pkg::SAMPLE_BITS-1:0] adc_sample,
    input  logic                             q_full,
    output logic                             push,
    output ctsr_pkg::job_t                   job
);

    localparam logic [2:0] PS_HEADER  = 3'd0;
    localparam logic [2:0] PS_FIRST   = 3'd1;
    localparam logic [2:0] PS_RST_S   = 3'd2;
    localparam logic [2:0] PS_RST_T   = 3'd3;
    localparam logic [2:0] PS_OK_K    = 3'd4;
    localparam logic [2:0] PS_RST_END = 3'd5;
    localparam logic [2:0] PS_OK_END  = 3'd6;

    localparam logic [1:0] LS_WAIT   = 2'd0;
    localparam logic [1:0] LS_SEND   = 2'd1;
    localparam logic [1:0] LS_RESEND = 2'd2;

    logic [15:0]                      period_reg;
    logic [2:0]                       parser_reg, parser_next;
    logic                             en_reg, en_next;
    logic [1:0]                       link_reg, link_next;
    logic [ctsr_pkg::SAMPLE_BITS-1:0] latched_reg, latched_next;
    logic [15:0]                      cnt_reg, cnt_next, cnt_tick;
    logic                             due_reg, due_next, due_tick;
    logic                             frame;
    logic                             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        parser_next = parser_reg;
        en_next     = en_reg;
        if (!mode)
        begin
            unique case (parser_reg)
                PS_HEADER:
                begin
                    if (rx_byte == ctsr_pkg::CH_BANG)
                    begin
                        parser_next = PS_FIRST;
                    end
                end
                PS_FIRST:
                begin
                    priority if (rx_byte == ctsr_pkg::CH_R)
                    begin
                        parser_next = PS_RST_S;
                    end
                    else if (rx_byte == ctsr_pkg::CH_O)
                    begin
                        parser_next = PS_OK_K;
                    end
                    else
                    begin
                        parser_next = PS_HEADER;
                    end
                end
                PS_RST_S:
                begin
                    parser_next = (rx_byte == ctsr_pkg::CH_S) ? PS_RST_T : PS_HEADER;
                end
                PS_RST_T:
                begin
                    parser_next = (rx_byte == ctsr_pkg::CH_T) ? PS_RST_END : PS_HEADER;
                end
                PS_OK_K:
                begin
                    parser_next = (rx_byte == ctsr_pkg::CH_K) ? PS_OK_END : PS_HEADER;
                end
                PS_RST_END:
                begin
                    if (rx_byte == ctsr_pkg::CH_HASH)
                    begin
                        en_next = 1'b1;
                    end
                    parser_next = PS_HEADER;
                end
                PS_OK_END:
                begin
                    if (rx_byte == ctsr_pkg::CH_HASH)
                    begin
                        en_next = 1'b0;
                    end
                    parser_next = PS_HEADER;
                end
                default:
                begin
                    parser_next = PS_HEADER;
                end
            endcase
        end
    end

    // timer tick
    always_comb
    begin
        cnt_tick = cnt_reg;
        due_tick = due_reg;
        if (mode && (cnt_reg != 16'd0))
        begin
            cnt_tick = cnt_reg - 16'd1;
            if (cnt_tick == 16'd0)
            begin
                due_tick = 1'b1;
            end
        end
    end

    always_comb
    begin
        link_next    = link_reg;
        latched_next = latched_reg;
        cnt_next     = cnt_tick;
        due_next     = due_tick;
        frame        = 1'b0;
        unique case (link_reg)
            LS_WAIT:
            begin
                if (en_next)
                begin
                    link_next    = LS_SEND;
                    latched_next = adc_sample;
                end
            end
            LS_SEND:
            begin
                frame = 1'b1;
                if (en_next)
                begin
                    link_next = LS_RESEND;
                    cnt_next  = period_reg;
                    due_next  = 1'b0;
                end
                else
                begin
                    link_next = LS_WAIT;
                end
            end
            LS_RESEND:
            begin
                if (due_tick)
                begin
                    frame    = 1'b1;
                    cnt_next = period_reg;
                    due_next = 1'b0;
                end
                if (!en_next)
                begin
                    link_next = LS_WAIT;
                    cnt_next  = 16'd0;
                    due_next  = 1'b0;
                end
            end
            default:
            begin
                link_next = LS_WAIT;
            end
        endcase
    end

    assign job.echo_en   = !mode;
    assign job.echo_byte = rx_byte;
    assign job.frame_en  = frame;
    assign job.sample    = latched_reg;
    assign push          = accept && (!mode || frame);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= ctsr_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parser_reg  <= PS_HEADER;
            en_reg      <= 1'b0;
            link_reg    <= LS_WAIT;
            latched_reg <= '0;
            cnt_reg     <= 16'd0;
            due_reg     <= 1'b0;
        end
        else if (accept)
        begin
            parser_reg  <= parser_next;
            en_reg      <= en_next;
            link_reg    <= link_next;
            latched_reg <= latched_next;
            cnt_reg     <= cnt_next;
            due_reg     <= due_next;
        end
    end

endmodule

// ===== design/ctsr_queue.sv =====
// job queue between the front end and the byte sequencer
// depends on ctsr_pkg
module ctsr_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ctsr_pkg::job_t din,
    input  logic           pop,
    output ctsr_pkg::job_t dout,
    output logic           full,
    output logic           empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctsr_pkg::job_t   mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/ctsr_back.sv =====
// byte sequencer: echo, frame header, decimal digits, frame tail
// depends on ctsr_pkg
module ctsr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  ctsr_pkg::job_t job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     tx_byte,
    output logic           last
);

    localparam int SB         = ctsr_pkg::SAMPLE_BITS;
    localparam int RECIP_TEN  = 6554;
    localparam int RECIP_SH   = 16;
    localparam int PROD_W     = SB + RECIP_SH;
    localparam int W4         = SB + 4;

    localparam logic [1:0] PH_ECHO = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = ctsr_pkg::CH_BANG;
            3'd1:    c = ctsr_pkg::CH_A;
            3'd2:    c = ctsr_pkg::CH_D;
            3'd3:    c = ctsr_pkg::CH_C;
            default: c = ctsr_pkg::CH_EQ;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tail_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = ctsr_pkg::CH_HASH;
            3'd1:    c = ctsr_pkg::CH_CR;
            default: c = ctsr_pkg::CH_LF;
        endcase
        return c;
    endfunction

    logic          busy_reg, busy_next;
    logic [1:0]    phase_reg, phase_next;
    logic [2:0]    idx_reg, idx_next;
    logic [7:0]    echo_reg, echo_next;
    logic          frame_reg, frame_next;
    logic [SB-1:0] conv_v_reg, conv_v_next;
    logic [1:0]    conv_k_reg, conv_k_next;
    logic          conv_done_reg, conv_done_next;
    logic [1:0]    dpos_reg, dpos_next;
    logic [3:0]    digit_reg [ctsr_pkg::DIGITS];
    logic          digit_we;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    tx_reg, tx_next;
    logic          last_reg, last_next;

    logic          can_load, emit, byte_last, job_end;
    logic [7:0]    byte_val;

    logic [PROD_W-1:0] prod;
    logic [SB-1:0]     q0, q;
    logic [W4-1:0]     tenq, v_ext, rem;
    logic [3:0]        rdig;

    // divide by ten through a reciprocal with one correction step
    always_comb
    begin
        prod  = PROD_W'(conv_v_reg) * PROD_W'(RECIP_TEN);
        q0    = prod[PROD_W-1 -: SB];
        tenq  = W4'({q0, 3'b000}) + W4'({q0, 1'b0});
        v_ext = W4'(conv_v_reg);
        if (tenq > v_ext)
        begin
            q   = q0 - 1'b1;
            rem = v_ext + W4'(10) - tenq;
        end
        else
        begin
            q   = q0;
            rem = v_ext - tenq;
        end
        rdig = rem[3:0];
    end

    assign can_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        echo_next      = echo_reg;
        frame_next     = frame_reg;
        conv_v_next    = conv_v_reg;
        conv_k_next    = conv_k_reg;
        conv_done_next = conv_done_reg;
        dpos_next      = dpos_reg;
        digit_we       = 1'b0;
        emit           = 1'b0;
        byte_val       = 8'h00;
        byte_last      = 1'b0;
        job_end        = 1'b0;

        if (!conv_done_reg)
        begin
            digit_we    = 1'b1;
            conv_k_next = conv_k_reg + 1'b1;
            conv_v_next = q;
            if ((q == '0) || (conv_k_reg == 2'(ctsr_pkg::DIGITS - 1)))
            begin
                conv_done_next = 1'b1;
                dpos_next      = conv_k_reg;
            end
        end

        if (busy_reg && can_load)
        begin
            unique case (phase_reg)
                PH_ECHO:
                begin
                    emit      = 1'b1;
                    byte_val  = echo_reg;
                    byte_last = !frame_reg;
                    if (frame_reg)
                    begin
                        phase_next = PH_HEAD;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        job_end = 1'b1;
                    end
                end
                PH_HEAD:
                begin
                    emit     = 1'b1;
                    byte_val = head_char(idx_reg);
                    if (idx_reg == 3'd4)
                    begin
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                PH_DIG:
                begin
                    if (conv_done_reg)
                    begin
                        emit     = 1'b1;
                        byte_val = ctsr_pkg::CH_ZERO + {4'b0000, digit_reg[dpos_reg]};
                        if (dpos_reg == 2'd0)
                        begin
                            phase_next = PH_TAIL;
                            idx_next   = 3'd0;
                        end
                        else
                        begin
                            dpos_next = dpos_reg - 2'd1;
                        end
                    end
                end
                PH_TAIL:
                begin
                    emit     = 1'b1;
                    byte_val = tail_char(idx_reg);
                    if (idx_reg == 3'd2)
                    begin
                        byte_last = 1'b1;
                        job_end   = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            endcase
        end

        if (job_end)
        begin
            busy_next = 1'b0;
        end

        pop = job_valid && (!busy_reg || job_end);
        if (pop)
        begin
            busy_next      = 1'b1;
            echo_next      = job.echo_byte;
            frame_next     = job.frame_en;
            phase_next     = job.echo_en ? PH_ECHO : PH_HEAD;
            idx_next       = 3'd0;
            conv_v_next    = job.sample;
            conv_k_next    = 2'd0;
            conv_done_next = !job.frame_en;
        end

        out_valid_next = out_valid_reg;
        tx_next        = tx_reg;
        last_next      = last_reg;
        if (can_load)
        begin
            out_valid_next = emit;
            tx_next        = byte_val;
            last_next      = byte_last;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg   <= echo_next;
        frame_reg  <= frame_next;
        conv_v_reg <= conv_v_next;
        tx_reg     <= tx_next;
        last_reg   <= last_next;
        if (digit_we)
        begin
            digit_reg[conv_k_reg] <= rdig;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_ECHO;
            idx_reg       <= 3'd0;
            conv_k_reg    <= 2'd0;
            conv_done_reg <= 1'b1;
            dpos_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            conv_k_reg    <= conv_k_next;
            conv_done_reg <= conv_done_next;
            dpos_reg      <= dpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_reg;
    assign last      = last_reg;

endmodule

// ===== design/command_triggered_sample_reporter.sv =====
// command triggered sample reporter, top level
// depends on ctsr_pkg, ctsr_front, ctsr_queue, ctsr_back
//
// input channel (in_valid / in_stall): one beat is a received serial byte
// (mode 0, rx_byte) or one timer tick (mode 1), with the current adc_sample.
// output channel (out_valid / out_stall): one beat per transmitted byte,
// last marks the final byte caused by one input beat.
// cfg_wr_en / cfg_wr_data write the resend period in ticks.
// the front end takes one input beat per cycle and queues a job for any beat
// that produces bytes; up to QUEUE_DEPTH jobs wait, then in_stall rises.
// the back end sends one byte per cycle from an output register while
// out_stall is low: an echo is 1 byte, a report frame 9 to 12 bytes, echo
// plus frame at most 13 bytes, so sustained throughput is set by the bytes a
// beat produces. the first byte of a beat passes the queue and back end job
// registers before the output register shows it. frame digits come from a
// divide-by-ten unit, one digit a cycle, hidden behind the five header bytes.
// reset: parser waits for '!', reporting off, period 1000, queue empty.
// when out_stall is high the byte on the port holds; the queue keeps filling
// until full, and then in_stall holds off new input beats.
module command_triggered_sample_reporter
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [15:0]                      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [7:0]                       rx_byte,
    input  logic [ctsr_pkg::SAMPLE_BITS-1:0] adc_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       tx_byte,
    output logic                             last
);

    ctsr_pkg::job_t push_job, head_job;
    logic           push, pop, q_full, q_empty;

    ctsr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .rx_byte     (rx_byte),
        .adc_sample  (adc_sample),
        .q_full      (q_full),
        .push        (push),
        .job         (push_job)
    );

    ctsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_job),
        .pop   (pop),
        .dout  (head_job),
        .full  (q_full),
        .empty (q_empty)
    );

    ctsr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_byte   (tx_byte),
        .last      (last)
    );

endmodule

// ===== design/ctsr_checker.sv =====
// port level checks on the output beat stream, bound to the top level
// depends on ctsr_pkg and command_triggered_sample_reporter_defines.svh
`include "command_triggered_sample_reporter_defines.svh"

module ctsr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] tx_byte,
    input logic       last
);

    logic       beat;
    logic       in_group_reg;
    logic [7:0] prev_byte_reg;

    assign beat = out_valid && !out_stall;

    // previous beat was not the final one of its input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_group_reg  <= 1'b0;
            prev_byte_reg <= 8'h00;
        end
        else if (beat)
        begin
            in_group_reg  <= !last;
            prev_byte_reg <= tx_byte;
        end
    end

    `CTSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(last), "stalled output beat changed")
    `CTSR_ASSERT_NOW(a_group_end, beat && in_group_reg && last, tx_byte == ctsr_pkg::CH_LF, "multi-byte output does not end in line feed")
    `CTSR_ASSERT_NOW(a_echo_then_frame, beat && in_group_reg && (prev_byte_reg == ctsr_pkg::CH_LF), tx_byte == ctsr_pkg::CH_BANG, "echo not followed by frame start")

endmodule

bind command_triggered_sample_reporter ctsr_checker u_ctsr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last      (last)
);

// ===== verif/command_triggered_sample_reporter_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for command_triggered_sample_reporter: a scoreboard
// predicts echo and report frame bytes per input beat and checks each output beat
// depends on ctsr_pkg and the command_triggered_sample_reporter rtl
module command_triggered_sample_reporter_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int SMP_W        = ctsr_pkg::SAMPLE_BITS;

    typedef enum logic [2:0]
    {
        P_HEADER,
        P_FIRST,
        P_RST_S,
        P_RST_T,
        P_OK_K,
        P_RST_END,
        P_OK_END
    } parse_state_t;

    typedef enum logic [1:0]
    {
        L_WAIT,
        L_SEND,
        L_RESEND
    } link_state_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    class tx_byte_scoreboard;
        logic [15:0]      period;
        parse_state_t     parse_st;
        logic             enabled;
        link_state_t      link_st;
        logic [SMP_W-1:0] held_sample;
        logic [15:0]      countdown;
        logic             due;
        tx_beat_t         tx_expected[$];
        int               errors;

        function new();
            period      = ctsr_pkg::PERIOD_RESET;
            parse_st    = P_HEADER;
            enabled     = 1'b0;
            link_st     = L_WAIT;
            held_sample = '0;
            countdown   = '0;
            due         = 1'b0;
            errors      = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            tx_expected.push_back('{data: b, last: 1'b0});
        endfunction

        function void push_frame();
            logic [7:0] digit[ctsr_pkg::DIGITS];
            int         v;
            int         k;
            v = int'(held_sample);
            k = 0;
            push_byte(ctsr_pkg::CH_BANG);
            push_byte(ctsr_pkg::CH_A);
            push_byte(ctsr_pkg::CH_D);
            push_byte(ctsr_pkg::CH_C);
            push_byte(ctsr_pkg::CH_EQ);
            do
            begin
                digit[k] = ctsr_pkg::CH_ZERO + 8'(v % 10);
                v = v / 10;
                k++;
            end
            while (v != 0 && k < ctsr_pkg::DIGITS);
            while (k > 0)
            begin
                k--;
                push_byte(digit[k]);
            end
            push_byte(ctsr_pkg::CH_HASH);
            push_byte(ctsr_pkg::CH_CR);
            push_byte(ctsr_pkg::CH_LF);
        endfunction

        function void note_beat(logic m, logic [7:0] c, logic [SMP_W-1:0] s);
            int start;
            start = tx_expected.size();
            if (!m)
            begin
                push_byte(c);
                case (parse_st)
                    P_HEADER:  if (c == ctsr_pkg::CH_BANG) parse_st = P_FIRST;
                    P_FIRST:
                    begin
                        if (c == ctsr_pkg::CH_R)
                            parse_st = P_RST_S;
                        else if (c == ctsr_pkg::CH_O)
                            parse_st = P_OK_K;
                        else
                            parse_st = P_HEADER;
                    end
                    P_RST_S:   parse_st = (c == ctsr_pkg::CH_S) ? P_RST_T : P_HEADER;
                    P_RST_T:   parse_st = (c == ctsr_pkg::CH_T) ? P_RST_END : P_HEADER;
                    P_OK_K:    parse_st = (c == ctsr_pkg::CH_K) ? P_OK_END : P_HEADER;
                    P_RST_END:
                    begin
                        if (c == ctsr_pkg::CH_HASH) enabled = 1'b1;
                        parse_st = P_HEADER;
                    end
                    P_OK_END:
                    begin
                        if (c == ctsr_pkg::CH_HASH) enabled = 1'b0;
                        parse_st = P_HEADER;
                    end
                    default:   parse_st = P_HEADER;
                endcase
            end
            else if (countdown != 0)
            begin
                countdown--;
                if (countdown == 0) due = 1'b1;
            end
            case (link_st)
                L_WAIT:
                begin
                    if (enabled)
                    begin
                        link_st     = L_SEND;
                        held_sample = s;
                    end
                end
                L_SEND:
                begin
                    push_frame();
                    if (enabled)
                    begin
                        link_st   = L_RESEND;
                        countdown = period;
                        due       = 1'b0;
                    end
                    else
                        link_st = L_WAIT;
                end
                L_RESEND:
                begin
                    if (due)
                    begin
                        push_frame();
                        countdown = period;
                        due       = 1'b0;
                    end
                    if (!enabled)
                    begin
                        link_st   = L_WAIT;
                        countdown = '0;
                        due       = 1'b0;
                    end
                end
                default: link_st = L_WAIT;
            endcase
            if (tx_expected.size() > start)
                tx_expected[tx_expected.size() - 1].last = 1'b1;
        endfunction

        function void check_tx(logic [7:0] tx, logic lst);
            tx_beat_t exp;
            if (tx_expected.size() == 0)
            begin
                $error("unexpected output beat: tx_byte %h, last %b", tx, lst);
                errors++;
                return;
            end
            exp = tx_expected.pop_front();
            if (tx !== exp.data)
            begin
                $error("tx_byte mismatch: expected %h, actual %h", exp.data, tx);
                errors++;
            end
            if (lst !== exp.last)
            begin
                $error("last mismatch: expected %b, actual %b", exp.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return tx_expected.size();
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [15:0]      cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic             mode        = 1'b0;
    logic [7:0]       rx_byte     = '0;
    logic [SMP_W-1:0] adc_sample  = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [7:0]       tx_byte;
    logic             last;

    tx_byte_scoreboard sb;
    int send_pct    = 0;
    int recv_pct    = 0;
    int beats_sent  = 0;
    int hold_id     = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    command_triggered_sample_reporter u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .rx_byte     (rx_byte),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .last        (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("command_triggered_sample_reporter_test: done, errors");
            $finish;
        end
    end

    // output side: check accepted beats, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_tx(tx_byte, last);
        if (hold_id != hold_seen)
        begin
            hold_seen = hold_id;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_pct);
    end

    function automatic logic [SMP_W-1:0] random_sample();
        int corner[8] = '{0, 9, 10, 99, 100, 999, 1000, 4095};
        if ($urandom_range(3) == 0)
            return SMP_W'(corner[$urandom_range(7)]);
        return SMP_W'($urandom_range(4095));
    endfunction

    task automatic send_beat(input logic m, input logic [7:0] c,
                             input logic [SMP_W-1:0] s);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        rx_byte    <= c;
        adc_sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(m, c, s);
        beats_sent++;
    endtask

    // fixed_sample below zero picks a fresh sample per beat
    task automatic send_text(input string s, input int fixed_sample);
        logic [SMP_W-1:0] smp;
        for (int i = 0; i < s.len(); i++)
        begin
            smp = (fixed_sample < 0) ? random_sample() : fixed_sample[SMP_W-1:0];
            send_beat(1'b0, s[i], smp);
        end
    endtask

    task automatic send_tick(input logic [SMP_W-1:0] s);
        send_beat(1'b1, 8'($urandom), s);
    endtask

    task automatic send_random(input int count);
        int    target;
        int    n;
        string cmd;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            case ($urandom_range(9))
                0, 1, 2: send_text("!RST#", -1);
                3, 4:    send_text("!OK#", -1);
                5:
                begin
                    cmd = $urandom_range(1) ? "!RST#" : "!OK#";
                    n = $urandom_range(1, cmd.len() - 1);
                    send_text(cmd.substr(0, n - 1), -1);
                    send_beat(1'b0, 8'($urandom), random_sample());
                end
                6, 7:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n) send_tick(random_sample());
                end
                8:       send_beat(1'b0, 8'($urandom), random_sample());
                default: send_tick(random_sample());
            endcase
        end
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_resend_period(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.period = v;
    endtask

    task automatic run_phase(input logic [15:0] period, input int spct, input int rpct,
                             input int count);
        settle_idle();
        write_resend_period(period);
        send_pct = spct;
        recv_pct = rpct;
        send_random(count);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, enable with largest sample, first frame on a tick,
        // disable, broken commands, re-enable with zero sample
        send_beat(1'b0, 8'h00, '0);
        send_beat(1'b0, 8'hFF, '1);
        send_text("!RST#", 4095);
        send_tick('0);
        send_text("!OK#", 123);
        send_text("!RSX", -1);
        send_text("!OX", -1);
        send_text("!RST#", 0);

        run_phase(16'd1, 0, 0, 78);
        run_phase(16'd3, 49, 0, 78);
        run_phase(16'd0, 0, 49, 78);
        run_phase(16'hFFFF, 22, 22, 78);
        run_phase(16'($urandom_range(2, 12)), 0, 0, 78);

        // long output hold-off while input keeps coming
        settle_idle();
        write_resend_period(16'd5);
        send_pct = 0;
        recv_pct = 0;
        hold_id++;
        send_text("!RST#", -1);
        send_random(40);

        settle_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("command_triggered_sample_reporter_test: done, clean");
        else
            $display("command_triggered_sample_reporter_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ctsr_pkg.sv
design/ctsr_front.sv
design/ctsr_queue.sv
design/ctsr_back.sv
design/command_triggered_sample_reporter.sv
design/ctsr_checker.sv
verif/command_triggered_sample_reporter_test.sv
